>>> rtl/ps2mp_pkg.sv
// ----------------------------------------------------------------------------
// ps2mp_pkg
// Shared types and constants for the PS/2 mouse packet to pulse converter.
// ----------------------------------------------------------------------------
package ps2mp_pkg;

  typedef enum logic [1:0] {
    CMD_NONE     = 2'd0,
    CMD_RESEND   = 2'd1,
    CMD_RESET    = 2'd2,
    CMD_POWER_ON = 2'd3
  } ps2mp_cmd_e;

  localparam logic [7:0] PowerOnCode = 8'hAA;
  localparam int unsigned SyncBit    = 3;
  localparam int unsigned XSignBit   = 5;
  localparam int unsigned YSignBit   = 4;
  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
    logic       parity_ok;
  } ps2mp_in_t;

  typedef struct packed {
    ps2mp_cmd_e command_request;
    logic       pulse_left;
    logic       pulse_right;
    logic       pulse_up;
    logic       pulse_down;
    logic [2:0] buttons;
    logic       host_interrupt;
  } ps2mp_out_t;

  // Classified work passed from the front to the back.
  typedef struct packed {
    logic       tick;
    ps2mp_cmd_e cmd;
    logic       notify;
    logic       update;
    logic [2:0] btn;
    logic       x_left;
    logic [7:0] x_mag;
    logic       y_up;
    logic [7:0] y_mag;
  } ps2mp_op_t;

endpackage

>>> rtl/ps2mp_front.sv
// ----------------------------------------------------------------------------
// ps2mp_front
// Accepts beats, tracks parity resends and packet assembly, emits work items.
// ----------------------------------------------------------------------------
module ps2mp_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ps2mp_pkg::ps2mp_in_t  in_data_i,
  output logic                  push_valid_o,
  input  logic                  push_ready_i,
  output ps2mp_pkg::ps2mp_op_t  push_data_o
);
  import ps2mp_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic [7:0] hdr_q, hdr_d;
  logic [7:0] x_q, x_d;
  logic       resend_q, resend_d;
  logic       accept;
  ps2mp_op_t  op;

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;
  assign accept       = in_valid_i && push_ready_i;
  assign push_data_o  = op;

  always_comb begin
    idx_d     = idx_q;
    hdr_d     = hdr_q;
    x_d       = x_q;
    resend_d  = resend_q;
    op        = '0;
    op.cmd    = CMD_NONE;
    op.btn    = hdr_q[2:0];
    op.x_left = hdr_q[XSignBit];
    op.x_mag  = hdr_q[XSignBit] ? 8'(8'd0 - x_q) : x_q;
    op.y_up   = hdr_q[YSignBit];
    op.y_mag  = hdr_q[YSignBit] ? 8'(8'd0 - in_data_i.data_byte) : in_data_i.data_byte;
    if (in_data_i.operation) begin
      op.tick = 1'b1;
    end else if (!in_data_i.parity_ok && !resend_q) begin
      op.cmd   = CMD_RESEND;
      resend_d = 1'b1;
      idx_d    = 2'd0;
    end else begin
      resend_d = 1'b0;
      if (in_data_i.data_byte == PowerOnCode) begin
        op.cmd = CMD_POWER_ON;
      end else begin
        op.notify = 1'b1;
        case (idx_q)
          2'd0: begin
            hdr_d = in_data_i.data_byte;
            idx_d = 2'd1;
          end
          2'd1: begin
            x_d   = in_data_i.data_byte;
            idx_d = 2'd2;
          end
          default: begin
            idx_d = 2'd0;
            if (hdr_q[SyncBit]) begin
              op.update = 1'b1;
            end else begin
              op.cmd = CMD_RESET;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= 2'd0;
      hdr_q    <= 8'd0;
      x_q      <= 8'd0;
      resend_q <= 1'b0;
    end else if (accept) begin
      idx_q    <= idx_d;
      hdr_q    <= hdr_d;
      x_q      <= x_d;
      resend_q <= resend_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) resend_q |-> idx_q == 2'd0)
    else $error("resend pending with packet partly assembled");

endmodule

>>> rtl/ps2mp_fifo.sv
// ----------------------------------------------------------------------------
// ps2mp_fifo
// Short register queue between the front and the back.
// ----------------------------------------------------------------------------
module ps2mp_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  output logic                 push_ready_o,
  input  ps2mp_pkg::ps2mp_op_t push_data_i,
  output logic                 pop_valid_o,
  input  logic                 pop_ready_i,
  output ps2mp_pkg::ps2mp_op_t pop_data_o
);
  import ps2mp_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  ps2mp_op_t       mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = cnt_q != CntW'(Depth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : PtrW'(p + 1'b1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) wptr_q <= wrap_inc(wptr_q);
      if (pop)  rptr_q <= wrap_inc(rptr_q);
      if (push && !pop) begin
        cnt_q <= CntW'(cnt_q + 1'b1);
      end else if (pop && !push) begin
        cnt_q <= CntW'(cnt_q - 1'b1);
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(Depth))
    else $error("queue fill count out of range");

endmodule

>>> rtl/ps2mp_back.sv
// ----------------------------------------------------------------------------
// ps2mp_back
// Applies work items to the movement counters and buttons, drives results.
// ----------------------------------------------------------------------------
module ps2mp_back #(
  parameter int unsigned CountWidth = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  op_valid_i,
  output logic                  op_ready_o,
  input  ps2mp_pkg::ps2mp_op_t  op_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ps2mp_pkg::ps2mp_out_t out_data_o
);
  import ps2mp_pkg::*;

  logic [CountWidth-1:0] left_q, left_d, right_q, right_d;
  logic [CountWidth-1:0] up_q, up_d, down_q, down_d;
  logic [2:0]            btn_q, btn_d;
  logic                  notify_q, notify_d;
  logic                  out_valid_q;
  ps2mp_out_t            out_q, res;
  logic                  pop;

  function automatic logic [CountWidth-1:0] sat_add(input logic [CountWidth-1:0] cnt,
                                                    input logic [7:0] mag);
    logic [CountWidth:0] sum;
    sum = {1'b0, cnt} + (CountWidth + 1)'(mag);
    return sum[CountWidth] ? '1 : sum[CountWidth-1:0];
  endfunction

  assign op_ready_o  = !out_valid_q || out_ready_i;
  assign pop         = op_valid_i && op_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    left_d  = left_q;
    right_d = right_q;
    up_d    = up_q;
    down_d  = down_q;
    btn_d   = btn_q;
    notify_d = notify_q;
    res     = '0;
    res.command_request = CMD_NONE;
    if (op_i.tick) begin
      res.pulse_left  = left_q  != '0;
      res.pulse_right = right_q != '0;
      res.pulse_up    = up_q    != '0;
      res.pulse_down  = down_q  != '0;
      left_d  = left_q  - CountWidth'(res.pulse_left);
      right_d = right_q - CountWidth'(res.pulse_right);
      up_d    = up_q    - CountWidth'(res.pulse_up);
      down_d  = down_q  - CountWidth'(res.pulse_down);
      if (!(res.pulse_left || res.pulse_right || res.pulse_up || res.pulse_down)
          && notify_q) begin
        res.host_interrupt = 1'b1;
        notify_d           = 1'b0;
      end
    end else begin
      res.command_request = op_i.cmd;
      if (op_i.notify) notify_d = 1'b1;
      if (op_i.update) begin
        btn_d = op_i.btn;
        if (op_i.x_left) left_d  = sat_add(left_q, op_i.x_mag);
        else             right_d = sat_add(right_q, op_i.x_mag);
        if (op_i.y_up)   up_d    = sat_add(up_q, op_i.y_mag);
        else             down_d  = sat_add(down_q, op_i.y_mag);
      end
    end
    res.buttons = btn_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q      <= '0;
      right_q     <= '0;
      up_q        <= '0;
      down_q      <= '0;
      btn_q       <= 3'd0;
      notify_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        left_q   <= left_d;
        right_q  <= right_d;
        up_q     <= up_d;
        down_q   <= down_d;
        btn_q    <= btn_d;
        notify_q <= notify_d;
      end
      if (pop) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_q <= res;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_q.host_interrupt |->
      !(out_q.pulse_left || out_q.pulse_right || out_q.pulse_up || out_q.pulse_down))
    else $error("host interrupt raised while counters still pulsing");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !op_i.tick |=> left_q >= $past(left_q) && down_q >= $past(down_q))
    else $error("counter decreased on a data beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_q.pulse_left || out_q.pulse_down) |->
      out_q.command_request == CMD_NONE)
    else $error("command raised on a tick result");

endmodule

>>> rtl/ps2_mouse_packet_to_pulses.sv
// ----------------------------------------------------------------------------
// ps2_mouse_packet_to_pulses
// Decodes PS/2 mouse bytes into button state and direction count pulses.
//
//   Channel  Dir  Handshake                Payload
//   in       in   in_valid_i / in_ready_o  in_data_i  (operation, byte, parity)
//   out      out  out_valid_o / out_ready_i out_data_o (command, pulses, buttons)
//
// One beat per cycle while the output is not stalled; each beat is classified
// into the queue, then its counter update is registered into the output reg.
// Reset clears packet assembly, counters, buttons and the queue at once.
// A stalled output fills the output register, then the two-entry queue, and
// only then drops in_ready_o.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_to_pulses #(
  parameter int unsigned COUNT_WIDTH = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ps2mp_pkg::ps2mp_in_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ps2mp_pkg::ps2mp_out_t out_data_o
);
  import ps2mp_pkg::*;

  logic      push_valid, push_ready;
  ps2mp_op_t push_data;
  logic      pop_valid, pop_ready;
  ps2mp_op_t pop_data;

  ps2mp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  ps2mp_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  ps2mp_back #(
    .CountWidth (COUNT_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (pop_valid),
    .op_ready_o  (pop_ready),
    .op_i        (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
